// ===== design/lpht_pkg.sv =====
// ----------------------------------------------------------------------------
// lpht_pkg
// shared types, request and status codes for the linear probe hash table
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int CAPACITY_DEF      = 1021;
    localparam int MAX_KEY_BYTES_DEF = 32;
    localparam int KEY_WORDS         = 4;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_SET    = 2'd2,
        REQ_REMOVE = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_PRESENT   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [5:0]  key_len;
        logic [63:0] key_w0;
        logic [63:0] key_w1;
        logic [63:0] key_w2;
        logic [63:0] key_w3;
        logic [31:0] value_in;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [31:0] value_out;
    } out_word_t;

endpackage

// ===== design/lpht_ram.sv =====
// ----------------------------------------------------------------------------
// lpht_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ===== design/lpht_hash.sv =====
// ----------------------------------------------------------------------------
// lpht_hash
// sdbm hash, one byte per cycle, then modulo by reciprocal multiply and fixup
// ----------------------------------------------------------------------------
module lpht_hash #(
    parameter int CAPACITY      = lpht_pkg::CAPACITY_DEF,
    parameter int MAX_KEY_BYTES = lpht_pkg::MAX_KEY_BYTES_DEF,
    localparam int IW = $clog2(CAPACITY)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [5:0]                  len,
    input  logic [8*MAX_KEY_BYTES-1:0]  key,
    output logic                        done,
    output logic [IW-1:0]               index
);

    typedef enum logic [2:0] { H_IDLE, H_BYTE, H_MUL, H_SUB, H_FIX } hstate_t;

    // quotient estimate is product >> QS, low by at most one
    localparam int          QS    = 32 + IW;
    localparam logic [32:0] RECIP = 33'((64'd1 << QS) / CAPACITY);

    hstate_t      state_reg;
    logic [31:0]  h_reg;
    logic [5:0]   cnt_reg;
    logic [64:0]  prod_reg;
    logic [31:0]  b_ext;
    logic [7:0]   b;
    logic [31:0]  qc;

    assign b     = key[cnt_reg[$clog2(MAX_KEY_BYTES)-1:0]*8 +: 8];
    assign b_ext = {{24{b[7]}}, b};
    assign qc    = 32'(prod_reg[64:QS]) * 32'(CAPACITY);
    assign index = h_reg[IW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            done      <= 1'b0;
            h_reg     <= '0;
            cnt_reg   <= '0;
            prod_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                H_IDLE:
                begin
                    if (start)
                    begin
                        h_reg     <= '0;
                        cnt_reg   <= '0;
                        state_reg <= (len == 6'd0) ? H_MUL : H_BYTE;
                    end
                end
                H_BYTE:
                begin
                    h_reg   <= b_ext + (h_reg << 6) + (h_reg << 16) - h_reg;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg + 6'd1 == len)
                    begin
                        state_reg <= H_MUL;
                    end
                end
                H_MUL:
                begin
                    prod_reg  <= 65'(h_reg) * 65'(RECIP);
                    state_reg <= H_SUB;
                end
                H_SUB:
                begin
                    h_reg     <= h_reg - qc;
                    state_reg <= H_FIX;
                end
                H_FIX:
                begin
                    if (h_reg >= 32'(CAPACITY))
                    begin
                        h_reg <= h_reg - 32'(CAPACITY);
                    end
                    state_reg <= H_IDLE;
                    done      <= 1'b1;
                end
                default: state_reg <= H_IDLE;
            endcase
        end
    end

endmodule

// ===== design/linear_probe_hash_table_core.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// open-addressing hash table with linear probing and deletion marks
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid/in_ready/in_data) carries one request word: type,
//   key length, four key words, value. out channel (out_valid/out_ready/
//   out_data) returns one result word per request: status, found, value.
//   one request at a time: in_ready is low from accept until the result
//   word has been taken.
// sequence: the hash is started, the key is run through sdbm byte by
//   byte (key_len clamped to MAX_KEY_BYTES), reduced modulo CAPACITY by
//   reciprocal multiply, subtract and fixup; the index is loaded, then
//   each probed slot takes a ram read, a compare and a step. the table
//   write happens on the last compare edge and out_valid rises right
//   after it.
// reset: occupied/deleted marks live in a ram cleared by a sweep over
//   all CAPACITY slots after reset; in_ready stays low until it finishes.
//   fill count is cleared at once.
// stall: the result word holds on out_data while out_ready is low and
//   no new request is taken.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core #(
    parameter int CAPACITY      = lpht_pkg::CAPACITY_DEF,
    parameter int MAX_KEY_BYTES = lpht_pkg::MAX_KEY_BYTES_DEF,
    localparam int IW = $clog2(CAPACITY)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lpht_pkg::in_word_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output lpht_pkg::out_word_t out_data
);

    localparam int KB = 8 * MAX_KEY_BYTES;

    typedef enum logic [2:0] { S_CLEAR, S_IDLE, S_HASH, S_READ, S_WAIT,
                               S_CHECK, S_OUT } state_t;

    state_t                state_reg;
    lpht_pkg::in_word_t    req_reg;
    logic [5:0]            len_reg;
    logic [KB-1:0]         key_reg;
    logic [IW-1:0]         pos_reg;
    logic [IW:0]           fill_reg;
    logic                  hash_start;
    logic                  hash_done;
    logic [IW-1:0]         hash_idx;
    lpht_pkg::out_word_t   out_reg;

    // ram ports
    logic [KB+6-1:0]       kw_wdata, kw_rdata;
    logic [31:0]           v_wdata, v_rdata;
    logic [1:0]            f_wdata, f_rdata;   // {occupied, deleted}
    logic                  we_k, we_v, we_f;

    logic [5:0]            len_c;
    logic [255:0]          key_all;
    logic [255:0]          mask;
    logic                  occ, del, same, live;
    logic [IW-1:0]         pos_inc;

    assign key_all = {in_data.key_w3, in_data.key_w2, in_data.key_w1, in_data.key_w0};
    assign len_c   = (in_data.key_len > 6'(MAX_KEY_BYTES)) ? 6'(MAX_KEY_BYTES)
                                                           : in_data.key_len;
    always_comb
    begin
        for (int i = 0; i < 32; i++)
        begin
            mask[i*8 +: 8] = (i < len_c) ? 8'hff : 8'h00;
        end
    end

    lpht_hash #(.CAPACITY(CAPACITY), .MAX_KEY_BYTES(MAX_KEY_BYTES)) u_hash (
        .clk(clk), .rst_n(rst_n), .start(hash_start), .len(len_reg),
        .key(key_reg), .done(hash_done), .index(hash_idx)
    );

    lpht_ram #(.WIDTH(KB+6), .DEPTH(CAPACITY)) u_key (
        .clk(clk), .we(we_k), .addr(pos_reg), .wdata(kw_wdata), .rdata(kw_rdata));
    lpht_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_val (
        .clk(clk), .we(we_v), .addr(pos_reg), .wdata(v_wdata), .rdata(v_rdata));
    lpht_ram #(.WIDTH(2), .DEPTH(CAPACITY)) u_flag (
        .clk(clk), .we(we_f), .addr(pos_reg), .wdata(f_wdata), .rdata(f_rdata));

    assign occ     = f_rdata[1];
    assign del     = f_rdata[0];
    assign same    = occ && (kw_rdata == {len_reg, key_reg});
    assign live    = same && !del;
    assign pos_inc = (pos_reg == IW'(CAPACITY - 1)) ? '0 : pos_reg + 1'b1;
    assign kw_wdata = {len_reg, key_reg};
    assign v_wdata  = req_reg.value_in;

    // write decisions at the check step and during the clear sweep
    always_comb
    begin
        we_k    = 1'b0;
        we_v    = 1'b0;
        we_f    = 1'b0;
        f_wdata = 2'b00;
        if (state_reg == S_CLEAR)
        begin
            we_f = 1'b1;
        end
        else if (state_reg == S_CHECK && (same || !occ))
        begin
            case (req_reg.req_type)
                lpht_pkg::REQ_INSERT:
                begin
                    if (same)
                    begin
                        we_v    = 1'b1;
                        we_f    = del;
                        f_wdata = 2'b10;
                    end
                    else if (32'(fill_reg + 1'b1) * 2 <= CAPACITY)
                    begin
                        we_k    = 1'b1;
                        we_v    = 1'b1;
                        we_f    = 1'b1;
                        f_wdata = 2'b10;
                    end
                end
                lpht_pkg::REQ_SET:    we_v = live;
                lpht_pkg::REQ_REMOVE:
                begin
                    we_f    = live;
                    f_wdata = 2'b11;
                end
                default: ;
            endcase
        end
    end

    assign hash_start = (state_reg == S_HASH) && !hash_done && (pos_reg == '1);
    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = (state_reg == S_OUT);
    assign out_data   = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            pos_reg   <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                S_CLEAR:
                begin
                    // sweep occupied/deleted marks to zero
                    if (pos_reg == IW'(CAPACITY - 1))
                    begin
                        pos_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        pos_reg <= pos_inc;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        req_reg   <= in_data;
                        len_reg   <= len_c;
                        key_reg   <= KB'(key_all & mask);
                        pos_reg   <= '1;    // marks hash not yet started
                        state_reg <= S_HASH;
                    end
                end
                S_HASH:
                begin
                    if (hash_start)
                    begin
                        pos_reg <= '0;
                    end
                    if (hash_done)
                    begin
                        pos_reg   <= hash_idx;
                        state_reg <= S_READ;
                    end
                end
                S_READ:  state_reg <= S_WAIT;
                S_WAIT:  state_reg <= S_CHECK;
                S_CHECK:
                begin
                    if (same || !occ)
                    begin
                        out_reg.found     <= live;
                        out_reg.value_out <= '0;
                        out_reg.status    <= live ? lpht_pkg::ST_PRESENT
                                                  : lpht_pkg::ST_NOT_FOUND;
                        case (req_reg.req_type)
                            lpht_pkg::REQ_INSERT:
                            begin
                                if (same)
                                begin
                                    out_reg.status <= del ? lpht_pkg::ST_INSERTED
                                                          : lpht_pkg::ST_PRESENT;
                                end
                                else if (we_k)
                                begin
                                    out_reg.status <= lpht_pkg::ST_INSERTED;
                                    fill_reg       <= fill_reg + 1'b1;
                                end
                                else
                                begin
                                    out_reg.status <= lpht_pkg::ST_FULL;
                                end
                            end
                            lpht_pkg::REQ_LOOKUP:
                            begin
                                out_reg.value_out <= live ? v_rdata : 32'd0;
                            end
                            default: ;
                        endcase
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        pos_reg   <= pos_inc;
                        state_reg <= S_READ;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== design/lpht_checker.sv =====
// ----------------------------------------------------------------------------
// lpht_checker
// port-level checks for the hash table core
// ----------------------------------------------------------------------------
module lpht_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input lpht_pkg::out_word_t out_data
);

    // one request in flight: no accept while a result waits
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready while result pending");

    // result word holds while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result dropped or changed under stall");

    // value is only returned with a present status
    a_val: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != lpht_pkg::ST_PRESENT |->
        out_data.value_out == 32'd0) else $error("stray value");

    // found goes with a present status; revive never sets found
    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.found |-> out_data.status == lpht_pkg::ST_PRESENT)
        else $error("found without present status");

    // accepting a request ends readiness
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready) else $error("ready after accept");

endmodule

bind linear_probe_hash_table_core lpht_checker u_lpht_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);

// ===== tb/sv/linear_probe_hash_table_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core_tb
// self-checking bench: directed corner cases, a random request mix over a
// reused key pool, then a fill until the table refuses new keys; every result
// word is checked against a behavioral table kept in the bench
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core_tb;

    localparam int CAP          = lpht_pkg::CAPACITY_DEF;
    localparam int MAXB         = lpht_pkg::MAX_KEY_BYTES_DEF;
    localparam int KW           = lpht_pkg::KEY_WORDS;
    localparam int LIMIT_CYCLES = 4000000;
    localparam int POOL_MAX     = 300;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    lpht_pkg::in_word_t  in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    lpht_pkg::out_word_t out_data;

    linear_probe_hash_table_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // shadow table: the bench's own copy of every slot
    logic [63:0] tbl_key [CAP][KW];
    int          tbl_len [CAP];
    logic [31:0] tbl_val [CAP];
    bit          tbl_occ [CAP];
    bit          tbl_del [CAP];
    int          tbl_fill;

    lpht_pkg::out_word_t pending_results[$];
    lpht_pkg::in_word_t  key_pool[$];

    int  errors;
    int  results_seen;
    int  words_sent;
    int  full_seen;
    int  revive_seen;
    int  cycles;
    bit  no_gaps;

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------

    // bytes of word w that fall inside an n-byte key
    function automatic logic [63:0] used_bytes(int n, int w);
        int c;
        c = n - w * 8;
        if (c <= 0)
            return 64'd0;
        if (c >= 8)
            return '1;
        return (64'd1 << (8 * c)) - 64'd1;
    endfunction

    function automatic int clamp_len(logic [5:0] len);
        return (len > MAXB) ? MAXB : int'(len);
    endfunction

    // sdbm over signed bytes, 32-bit wrap, reduced to a slot
    function automatic int sdbm_slot(logic [63:0] kw [KW], int n);
        logic [31:0] h;
        logic [7:0]  b;
        h = '0;
        for (int i = 0; i < n; i++)
        begin
            b = kw[i / 8][(i % 8) * 8 +: 8];
            h = {{24{b[7]}}, b} + (h << 6) + (h << 16) - h;
        end
        return int'(h % CAP);
    endfunction

    // apply one request to the shadow table and return its result word
    function automatic lpht_pkg::out_word_t table_apply(lpht_pkg::in_word_t w);
        logic [63:0]         kw [KW];
        int                  n, s, pos;
        bit                  hit, live, same;
        lpht_pkg::out_word_t r;
        lpht_pkg::req_t      op;
        n = clamp_len(w.key_len);
        kw[0] = w.key_w0 & used_bytes(n, 0);
        kw[1] = w.key_w1 & used_bytes(n, 1);
        kw[2] = w.key_w2 & used_bytes(n, 2);
        kw[3] = w.key_w3 & used_bytes(n, 3);
        s = sdbm_slot(kw, n);
        hit = 1'b0;
        pos = CAP;
        // linear probe until an unused slot or the key itself
        for (int k = 0; k < CAP; k++)
        begin
            if (!tbl_occ[s])
            begin
                pos = s;
                break;
            end
            same = (tbl_len[s] == n);
            for (int j = 0; j < KW; j++)
                if (tbl_key[s][j] != kw[j])
                    same = 1'b0;
            if (same)
            begin
                hit = 1'b1;
                pos = s;
                break;
            end
            s = (s + 1 == CAP) ? 0 : s + 1;
        end
        live = hit && !tbl_del[pos];
        r = '0;
        r.found = live;
        op = lpht_pkg::req_t'(w.req_type);
        case (op)
            lpht_pkg::REQ_INSERT:
            begin
                if (live)
                begin
                    tbl_val[pos] = w.value_in;
                    r.status = lpht_pkg::ST_PRESENT;
                end
                else if (hit)
                begin
                    // removed key comes back in its own slot, fill unchanged
                    tbl_del[pos] = 1'b0;
                    tbl_val[pos] = w.value_in;
                    r.status = lpht_pkg::ST_INSERTED;
                    revive_seen++;
                end
                else if (pos >= CAP || (tbl_fill + 1) * 2 > CAP)
                begin
                    r.status = lpht_pkg::ST_FULL;
                    full_seen++;
                end
                else
                begin
                    for (int j = 0; j < KW; j++)
                        tbl_key[pos][j] = kw[j];
                    tbl_len[pos] = n;
                    tbl_val[pos] = w.value_in;
                    tbl_occ[pos] = 1'b1;
                    tbl_del[pos] = 1'b0;
                    tbl_fill++;
                    r.status = lpht_pkg::ST_INSERTED;
                end
            end
            lpht_pkg::REQ_LOOKUP:
            begin
                r.status = live ? lpht_pkg::ST_PRESENT : lpht_pkg::ST_NOT_FOUND;
                if (live)
                    r.value_out = tbl_val[pos];
            end
            lpht_pkg::REQ_SET:
            begin
                r.status = live ? lpht_pkg::ST_PRESENT : lpht_pkg::ST_NOT_FOUND;
                if (live)
                    tbl_val[pos] = w.value_in;
            end
            default:
            begin
                r.status = live ? lpht_pkg::ST_PRESENT : lpht_pkg::ST_NOT_FOUND;
                if (live)
                    tbl_del[pos] = 1'b1;
            end
        endcase
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // fresh key: mostly short, some long, some over-long or empty
    function automatic lpht_pkg::in_word_t fresh_key();
        lpht_pkg::in_word_t k;
        int                 sel;
        k = '0;
        sel = $urandom_range(0, 19);
        if (sel < 10)
            k.key_len = 6'($urandom_range(1, 8));
        else if (sel < 16)
            k.key_len = 6'($urandom_range(9, 32));
        else if (sel < 19)
            k.key_len = 6'($urandom_range(33, 63));
        else
            k.key_len = 6'd0;
        k.key_w0 = rand64();
        k.key_w1 = rand64();
        k.key_w2 = rand64();
        k.key_w3 = rand64();
        return k;
    endfunction

    // same key with junk above its length, half the time
    function automatic lpht_pkg::in_word_t dirty_key(lpht_pkg::in_word_t k);
        int n;
        n = clamp_len(k.key_len);
        if ($urandom_range(0, 1))
        begin
            k.key_w0 = (k.key_w0 & used_bytes(n, 0)) | (rand64() & ~used_bytes(n, 0));
            k.key_w1 = (k.key_w1 & used_bytes(n, 1)) | (rand64() & ~used_bytes(n, 1));
            k.key_w2 = (k.key_w2 & used_bytes(n, 2)) | (rand64() & ~used_bytes(n, 2));
            k.key_w3 = (k.key_w3 & used_bytes(n, 3)) | (rand64() & ~used_bytes(n, 3));
        end
        return k;
    endfunction

    // ------------------------------------------------------------------
    // driving and checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, field, got, want);
        errors++;
    endtask

    // send one request word and predict its result at the accepting edge
    task automatic send_word(lpht_pkg::req_t op, lpht_pkg::in_word_t k,
                             logic [31:0] value);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 14);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        k.req_type = op;
        k.value_in = value;
        in_data  <= k;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(table_apply(k));
        words_sent++;
    endtask

    // drop valid and let every outstanding result come back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // result side stall: a random hold-off before each word
    initial
    begin
        int stall;
        forever
        begin
            @(negedge clk);
            stall = no_gaps ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // compare each taken result word with the oldest prediction
    always @(posedge clk)
    begin
        lpht_pkg::out_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("[%0t] result word with nothing pending", $time);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_seen++;
                if (out_data.status !== want.status)
                    report_mismatch("status", 32'(out_data.status), 32'(want.status));
                if (out_data.found !== want.found)
                    report_mismatch("found", 32'(out_data.found), 32'(want.found));
                if (out_data.value_out !== want.value_out)
                    report_mismatch("value_out", out_data.value_out, want.value_out);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // corner cases: empty key, over-long length, stray bytes, sign bit,
    // update, remove, revive, operations on absent keys
    task automatic test_directed();
        lpht_pkg::in_word_t a, b, e;
        e = '0;
        a = '0;
        a.key_len = 6'd63;
        a.key_w0 = '1;
        a.key_w1 = 64'h8080_8080_8080_8080;
        a.key_w2 = rand64();
        a.key_w3 = rand64();
        b = '0;
        b.key_len = 6'd1;
        b.key_w0 = 64'hFFFF_FFFF_FFFF_FF80;
        send_word(lpht_pkg::REQ_LOOKUP, e, 32'hFFFF_FFFF);
        send_word(lpht_pkg::REQ_INSERT, e, 32'h0);
        send_word(lpht_pkg::REQ_LOOKUP, e, 32'h0);
        send_word(lpht_pkg::REQ_INSERT, a, 32'hFFFF_FFFF);
        a.key_len = 6'd32;
        send_word(lpht_pkg::REQ_LOOKUP, a, 32'h0);
        send_word(lpht_pkg::REQ_INSERT, b, 32'h1234_5678);
        b.key_w0 = 64'h80;
        send_word(lpht_pkg::REQ_LOOKUP, b, 32'h0);
        send_word(lpht_pkg::REQ_INSERT, b, 32'hA5A5_5A5A);
        send_word(lpht_pkg::REQ_SET, b, 32'h0000_0001);
        send_word(lpht_pkg::REQ_LOOKUP, b, 32'h0);
        send_word(lpht_pkg::REQ_REMOVE, b, 32'h0);
        send_word(lpht_pkg::REQ_LOOKUP, b, 32'h0);
        send_word(lpht_pkg::REQ_SET, b, 32'h5);
        send_word(lpht_pkg::REQ_REMOVE, b, 32'h0);
        send_word(lpht_pkg::REQ_INSERT, b, 32'hDEAD_BEEF);
        send_word(lpht_pkg::REQ_LOOKUP, b, 32'h0);
        send_word(lpht_pkg::REQ_REMOVE, a, 32'h0);
        send_word(lpht_pkg::REQ_INSERT, a, 32'h0);
        send_word(lpht_pkg::REQ_REMOVE, e, 32'h0);
        send_word(lpht_pkg::REQ_LOOKUP, e, 32'h0);
        drain();
    endtask

    // random mix over a reused pool so most requests hit live or removed keys
    task automatic test_random_mix(int count);
        lpht_pkg::in_word_t k;
        lpht_pkg::req_t     op;
        int                 sel;
        for (int i = 0; i < count; i++)
        begin
            // alternate stretches with and without hold-offs
            if (i % 150 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            if (key_pool.size() == 0 || $urandom_range(0, 9) < 3)
            begin
                k = fresh_key();
                if (key_pool.size() < POOL_MAX)
                    key_pool.push_back(k);
            end
            else
                k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            sel = $urandom_range(0, 9);
            op = (sel < 4) ? lpht_pkg::REQ_INSERT : (sel < 6) ? lpht_pkg::REQ_LOOKUP :
                 (sel < 8) ? lpht_pkg::REQ_SET : lpht_pkg::REQ_REMOVE;
            send_word(op, dirty_key(k), $urandom);
        end
        no_gaps = 1'b0;
        drain();
    endtask

    // push fresh keys until inserts are refused, then probe the full table
    task automatic test_table_full();
        lpht_pkg::in_word_t k;
        no_gaps = 1'b1;
        while ((tbl_fill + 1) * 2 <= CAP)
        begin
            k = fresh_key();
            k.key_len = 6'($urandom_range(4, 8));
            send_word(lpht_pkg::REQ_INSERT, k, $urandom);
        end
        no_gaps = 1'b0;
        for (int i = 0; i < 12; i++)
            send_word(lpht_pkg::REQ_INSERT, fresh_key(), $urandom);
        for (int i = 0; i < 12; i++)
            send_word(lpht_pkg::req_t'($urandom_range(0, 3)),
                      dirty_key(key_pool[$urandom_range(0, key_pool.size() - 1)]),
                      $urandom);
        drain();
    endtask

    initial
    begin
        errors = 0;
        results_seen = 0;
        words_sent = 0;
        full_seen = 0;
        revive_seen = 0;
        cycles = 0;
        no_gaps = 1'b0;
        tbl_fill = 0;
        for (int i = 0; i < CAP; i++)
        begin
            tbl_occ[i] = 1'b0;
            tbl_del[i] = 1'b0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random_mix(800);
        test_table_full();

        $display("%0d request words, %0d results checked, %0d refused as full, %0d revived",
                 words_sent, results_seen, full_seen, revive_seen);
        $display("final fill %0d of %0d slots", tbl_fill, CAP);
        if (errors == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
        begin
            $display("%0d mismatches, %0d results missing", errors, pending_results.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/lpht_pkg.sv
design/lpht_ram.sv
design/lpht_hash.sv
design/linear_probe_hash_table_core.sv
design/lpht_checker.sv
tb/sv/linear_probe_hash_table_core_tb.sv
